// ===== src/dtr_pkg.sv =====
// Shared types, constants and the class renumbering function for the detection row decoder.
// Used by dtr_rank and detection_row_decode_topk; depends on nothing else.
`default_nettype none

package dtr_pkg;

    localparam int SAMPLE_W   = 18;
    localparam int THRESH_W   = 17;
    localparam int FRAME_W    = 12;
    localparam int PIXEL_W    = 14;
    localparam int EDGE_W     = 15;
    localparam int CLASS_W    = 7;
    localparam int POS_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_CLASSES = 4;

    localparam int CLASS_COUNT = 80;
    localparam int HEADER_LEN  = 5;

    localparam logic [CLASS_W-1:0] NO_CLASS = 7'd90;

    // Row positions of the header samples.
    localparam logic [POS_W-1:0] POS_CX  = 7'd0;
    localparam logic [POS_W-1:0] POS_CY  = 7'd1;
    localparam logic [POS_W-1:0] POS_W_  = 7'd2;
    localparam logic [POS_W-1:0] POS_H   = 7'd3;
    localparam logic [POS_W-1:0] POS_OBJ = 7'd4;
    localparam logic [POS_W-1:0] POS_LAST_CLASS = 7'(HEADER_LEN + CLASS_COUNT - 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    // Boundaries of the 80-to-90 class renumbering.
    localparam logic [CLASS_W-1:0] MAP_B0 = 7'd73;
    localparam logic [CLASS_W-1:0] MAP_B1 = 7'd62;
    localparam logic [CLASS_W-1:0] MAP_B2 = 7'd61;
    localparam logic [CLASS_W-1:0] MAP_B3 = 7'd60;
    localparam logic [CLASS_W-1:0] MAP_B4 = 7'd40;
    localparam logic [CLASS_W-1:0] MAP_B5 = 7'd26;
    localparam logic [CLASS_W-1:0] MAP_B6 = 7'd24;
    localparam logic [CLASS_W-1:0] MAP_B7 = 7'd11;

    typedef struct packed {
        logic clear;
        logic insert;
    } t_rank_ctl;

    function automatic logic [CLASS_W-1:0] map_class(input logic [CLASS_W-1:0] c);
        logic [CLASS_W-1:0] r;
        if (c >= MAP_B0)      r = c + 7'd10;
        else if (c >= MAP_B1) r = c + 7'd9;
        else if (c >= MAP_B2) r = c + 7'd8;
        else if (c >= MAP_B3) r = c + 7'd6;
        else if (c >= MAP_B4) r = c + 7'd5;
        else if (c >= MAP_B5) r = c + 7'd4;
        else if (c >= MAP_B6) r = c + 7'd2;
        else if (c >= MAP_B7) r = c + 7'd1;
        else                  r = c;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/detection_row_decode_topk.sv =====
// Detection row decoder: box scaling, objectness and top-ranked class selection per row.
// Depends on dtr_pkg and instantiates dtr_rank for the class ranking.
//
// Usage:
//   The input channel carries one row element per beat (i_sample, Q1.16), with
//   i_row_last on the final class score. A row is centre x, centre y, width,
//   height, objectness and then up to 80 class scores; the last class ends the
//   row even without the mark, and a mark inside the header aborts the row.
//   At the end of a row that passes the confidence threshold one result beat is
//   issued on the output channel: box edges and size in pixels, objectness,
//   best score and the four best classes in 90-class numbering.
//   One beat is taken every cycle while the input is not stalled. An accepted
//   beat waits in the input register and is processed from there into the
//   result register. The single result register lets beats that give no result
//   pass while a result waits; only a beat that ends a passing row stalls behind
//   an untaken result.
//   The configuration port is always ready and must be written only while idle.
//   Reset clears the row position, the ranked list and both valid flags and
//   restores threshold 0.5, frame 640 by 480.
`default_nettype none

module detection_row_decode_topk
    import dtr_pkg::*;
#(
    parameter int TOP_COUNT = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,

    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [THRESH_W-1:0]        i_cfg_data,

    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic                       i_row_last,

    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic signed [EDGE_W-1:0]        o_box_left,
    output logic signed [EDGE_W-1:0]        o_box_top,
    output logic signed [PIXEL_W-1:0]       o_box_width,
    output logic signed [PIXEL_W-1:0]       o_box_height,
    output logic signed [SAMPLE_W-1:0]      o_objectness,
    output logic signed [SAMPLE_W-1:0]      o_best_score,
    output logic [CLASS_W-1:0]              o_class_first,
    output logic [CLASS_W-1:0]              o_class_second,
    output logic [CLASS_W-1:0]              o_class_third,
    output logic [CLASS_W-1:0]              o_class_fourth
);

    localparam int PROD_W = SAMPLE_W + FRAME_W + 1;

    // Configuration.
    logic [THRESH_W-1:0] r_thresh;
    logic [FRAME_W-1:0]  r_frame_w;
    logic [FRAME_W-1:0]  r_frame_h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh  <= 17'd32768;
            r_frame_w <= 12'd640;
            r_frame_h <= 12'd480;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THRESHOLD:    r_thresh  <= i_cfg_data;
                CFG_FRAME_WIDTH:  r_frame_w <= i_cfg_data[FRAME_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_h <= i_cfg_data[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register.
    logic                       r_in_valid;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_last;

    // Row state.
    logic [POS_W-1:0]           r_pos;
    logic signed [PIXEL_W-1:0]  r_cx;
    logic signed [PIXEL_W-1:0]  r_cy;
    logic signed [PIXEL_W-1:0]  r_w;
    logic signed [PIXEL_W-1:0]  r_h;
    logic signed [SAMPLE_W-1:0] r_obj;

    // Result register.
    logic                       r_out_valid;

    logic                       w_header;
    logic                       w_row_end;
    logic                       w_pass;
    logic                       w_result;
    logic                       w_advance;
    logic [FRAME_W-1:0]         w_scale;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [PROD_W-1:0]   w_prod_adj;
    logic signed [PIXEL_W-1:0]  w_px;
    logic signed [PIXEL_W-1:0]  w_half_w;
    logic signed [PIXEL_W-1:0]  w_half_h;
    logic [CLASS_W-1:0]         w_class_idx;
    logic signed [SAMPLE_W-1:0] w_best;
    logic [CLASS_W-1:0]         w_class_id [OUT_CLASSES];
    t_rank_ctl                  w_rank_ctl;
    logic [POS_W-1:0]           n_pos;
    logic                       n_out_valid;

    assign w_header    = r_pos < 7'(HEADER_LEN);
    assign w_class_idx = r_pos - 7'(HEADER_LEN);
    assign w_row_end   = !w_header && (r_last || r_pos == POS_LAST_CLASS);

    // Width and x use the frame width, the others the frame height.
    assign w_scale    = (r_pos == POS_CX || r_pos == POS_W_) ? r_frame_w : r_frame_h;
    assign w_prod     = PROD_W'(r_sample) * $signed({1'b0, w_scale});
    assign w_prod_adj = w_prod + (w_prod[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
    assign w_px       = w_prod_adj[PIXEL_W+15:16];

    // Objectness and best score are both compared with the threshold as signed values one bit wider than a sample.
    assign w_pass = ($signed({r_obj[SAMPLE_W-1], r_obj}) >= $signed({2'b00, r_thresh}))
                 && ($signed({w_best[SAMPLE_W-1], w_best}) >= $signed({2'b00, r_thresh}));
    assign w_result  = w_row_end && w_pass;
    assign w_advance = r_in_valid && (!w_result || !r_out_valid || i_out_ready);

    assign o_in_ready = !r_in_valid || w_advance;

    assign w_rank_ctl.clear  = w_advance && r_pos == POS_OBJ;
    assign w_rank_ctl.insert = w_advance && !w_header;

    dtr_rank #(
        .TOP_COUNT (TOP_COUNT)
    ) u_rank (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_rank_ctl),
        .i_score      (r_sample),
        .i_index      (w_class_idx),
        .o_best_score (w_best),
        .o_class_id   (w_class_id)
    );

    always_comb begin
        if (w_header) begin
            n_pos = r_last ? '0 : r_pos + 7'd1;
        end else begin
            n_pos = w_row_end ? '0 : r_pos + 7'd1;
        end
    end

    always_comb begin
        if (w_advance && w_result) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_w         <= '0;
            r_h         <= '0;
            r_obj       <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_pos <= n_pos;
                case (r_pos)
                    POS_CX:  r_cx  <= w_px;
                    POS_CY:  r_cy  <= w_px;
                    POS_W_:  r_w   <= w_px;
                    POS_H:   r_h   <= w_px;
                    POS_OBJ: r_obj <= r_sample;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_sample <= i_sample;
            r_last   <= i_row_last;
        end
    end

    // Halving truncates toward zero, as the size is signed.
    assign w_half_w = (r_w + $signed({{(PIXEL_W-1){1'b0}}, r_w[PIXEL_W-1]})) >>> 1;
    assign w_half_h = (r_h + $signed({{(PIXEL_W-1){1'b0}}, r_h[PIXEL_W-1]})) >>> 1;

    always_ff @(posedge i_clk) begin
        if (w_advance && w_result) begin
            o_box_left     <= EDGE_W'(r_cx) - EDGE_W'(w_half_w);
            o_box_top      <= EDGE_W'(r_cy) - EDGE_W'(w_half_h);
            o_box_width    <= r_w;
            o_box_height   <= r_h;
            o_objectness   <= r_obj;
            o_best_score   <= w_best;
            o_class_first  <= w_class_id[0];
            o_class_second <= w_class_id[1];
            o_class_third  <= w_class_id[2];
            o_class_fourth <= w_class_id[3];
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== src/dtr_rank.sv =====
// Running ranked list of the best (score, class) pairs of one row, one insert per cycle.
// Depends on dtr_pkg for widths, the control struct and the class renumbering.
`default_nettype none

module dtr_rank
    import dtr_pkg::*;
#(
    parameter int TOP_COUNT = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_rank_ctl                  i_ctl,
    input  wire logic signed [SAMPLE_W-1:0] i_score,
    input  wire logic [CLASS_W-1:0]         i_index,
    output logic signed [SAMPLE_W-1:0]      o_best_score,
    output logic [CLASS_W-1:0]              o_class_id [OUT_CLASSES]
);

    logic signed [SAMPLE_W-1:0] r_score [TOP_COUNT];
    logic [CLASS_W-1:0]         r_index [TOP_COUNT];
    logic [TOP_COUNT-1:0]       r_vld;

    logic signed [SAMPLE_W-1:0] n_score [TOP_COUNT];
    logic [CLASS_W-1:0]         n_index [TOP_COUNT];
    logic [TOP_COUNT-1:0]       n_vld;
    logic [TOP_COUNT-1:0]       w_keep;

    // The list is sorted, so the entries that outrank the new score form a prefix.
    // Everything behind that prefix moves down by one place.
    always_comb begin
        for (int j = 0; j < TOP_COUNT; j++) begin
            w_keep[j] = r_vld[j] && (i_score < r_score[j]);
        end
        for (int j = 0; j < TOP_COUNT; j++) begin
            if (w_keep[j]) begin
                n_score[j] = r_score[j];
                n_index[j] = r_index[j];
            end else if (j == 0) begin
                n_score[j] = i_score;
                n_index[j] = i_index;
            end else if (w_keep[j-1]) begin
                n_score[j] = i_score;
                n_index[j] = i_index;
            end else begin
                n_score[j] = r_score[j-1];
                n_index[j] = r_index[j-1];
            end
            if (j == 0) begin
                n_vld[j] = 1'b1;
            end else begin
                n_vld[j] = r_vld[j] || r_vld[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.clear) begin
            r_vld <= '0;
        end else if (i_ctl.insert) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.insert) begin
            for (int j = 0; j < TOP_COUNT; j++) begin
                r_score[j] <= n_score[j];
                r_index[j] <= n_index[j];
            end
        end
    end

    // The row end is always a class sample, so the result is read from the updated list.
    assign o_best_score = n_score[0];

    for (genvar k = 0; k < OUT_CLASSES; k++) begin : g_class
        if (k < TOP_COUNT) begin : g_ranked
            assign o_class_id[k] = n_vld[k] ? map_class(n_index[k]) : NO_CLASS;
        end else begin : g_unranked
            assign o_class_id[k] = NO_CLASS;
        end
    end

endmodule

`default_nettype wire
